[rtl/fraction_add_reduce_macros.svh]
// assertion macros for the fraction adder
`ifndef FRACTION_ADD_REDUCE_MACROS_SVH
`define FRACTION_ADD_REDUCE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while arst_n is low
`define FAR_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion label failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define FAR_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion label failed");

`else

`define FAR_ASSERT_IMP(label, pre, post)
`define FAR_ASSERT_NXT(label, pre, post)

`endif

`endif

[rtl/far_pkg.sv]
// shared types and constants of the fraction adder
`default_nettype none

package far_pkg;

	// internal arithmetic width, all intermediates wrap at this size
	localparam int WIDE = 64;
	localparam int CNT_W = $clog2(WIDE);
	localparam int NUM_W = 33;
	localparam int DEN_W = 32;
	localparam int OUT_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;

	typedef logic [WIDE-1:0] wide_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// divider jobs, also select where the quotient lands
	typedef enum logic [1:0] {
		DIV_M1,
		DIV_M2,
		DIV_NUM,
		DIV_DEN
	} div_op_t;

	// kind of result written to the output register
	typedef enum logic [1:0] {
		RES_ERR,
		RES_ZERO,
		RES_SUM
	} res_kind_t;

	// gcd operand pair select
	localparam logic GCD_DEN = 1'b0;
	localparam logic GCD_SUM = 1'b1;

	typedef struct packed {
		logic      gcd_start;
		logic      gcd_sel;
		logic      div_start;
		div_op_t   div_op;
		logic      mul_en;
		logic      sum_en;
		logic      res_load;
		res_kind_t res_kind;
	} far_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic gcd_done;
		logic div_done;
		logic sum_zero;
		logic out_full;
	} far_sts_t;

endpackage

`default_nettype wire

[rtl/fraction_add_reduce.sv]
// top level of the fraction adder with reduction to lowest terms
//
// channel  dir  beats                                  payload
// s_*      in   one request per fraction pair          n1, d1, n2, d2
// m_*      out  one result per request                 reduced numerator, denominator, status
//
// one request at a time; a request is processed by
// two binary gcd runs (reduction steps plus shift-back) and four divisions
// a zero denominator request skips to the result write, a zero sum skips the second half
// reset is asynchronous and clears control only, no clearing pass
// a result waiting in the output register does not block the next request from entering
`default_nettype none

`include "fraction_add_reduce_macros.svh"

module fraction_add_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// first_numerator, first_denominator, second_numerator, second_denominator
	input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// sum_numerator, sum_denominator, zero pad
	output logic [far_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status
	output logic [0:0] m_tuser
);
	import far_pkg::*;

	localparam int W = OPERAND_WIDTH;

	far_cmd_t              cmd;
	far_sts_t              sts;
	logic                  in_accept;
	logic signed [NUM_W-1:0] res_num;
	logic [DEN_W-1:0]      res_den;
	logic                  res_status;

	assign in_accept = s_tvalid && s_tready;

	// controller
	far_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	far_dp #(
		.W (W)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (in_accept),
		.first_numerator    (s_tdata[W-1:0]),
		.first_denominator  (s_tdata[2*W-1:W]),
		.second_numerator   (s_tdata[3*W-1:2*W]),
		.second_denominator (s_tdata[4*W-1:3*W]),
		.cmd                (cmd),
		.sts                (sts),
		.out_ready          (m_tready),
		.out_valid          (m_tvalid),
		.sum_numerator      (res_num),
		.sum_denominator    (res_den),
		.status             (res_status)
	);

	// result packing
	assign m_tdata = {{(OUT_TDATA_W-NUM_W-DEN_W){1'b0}}, res_den, res_num};
	assign m_tuser = res_status;

	// checks
	`FAR_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, !s_tready)
	`FAR_ASSERT_IMP(a_err_den_zero, m_tvalid && m_tuser[0], res_den == '0)
	`FAR_ASSERT_IMP(a_err_num_zero, m_tvalid && m_tuser[0], res_num == '0)

endmodule

`default_nettype wire

[rtl/far_gcd.sv]
// binary gcd unit, one step per cycle, then shifts the common power of two back
`default_nettype none

module far_gcd (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire far_pkg::wide_t a_in,
	input  wire far_pkg::wide_t b_in,
	output far_pkg::wide_t      result,
	output logic               done
);
	import far_pkg::*;

	wide_t a_q;
	wide_t b_q;
	cnt_t  k_q;
	logic  run_q;
	logic  shl_q;
	logic  done_q;

	// reduction steps, both operands nonzero on start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			shl_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q   <= a_in;
				b_q   <= b_in;
				k_q   <= '0;
				run_q <= 1'b1;
				shl_q <= 1'b0;
			end else if (run_q) begin
				if (a_q == b_q) begin
					run_q <= 1'b0;
					shl_q <= 1'b1;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q > b_q) begin
					a_q <= (a_q - b_q) >> 1;
				end else begin
					b_q <= (b_q - a_q) >> 1;
				end
			end else if (shl_q) begin
				if (k_q == '0) begin
					shl_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					a_q <= a_q << 1;
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	assign result = a_q;
	assign done   = done_q;

endmodule

`default_nettype wire

[rtl/far_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module far_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire far_pkg::wide_t dividend,
	input  wire far_pkg::wide_t divisor,
	output far_pkg::wide_t      quotient,
	output logic               done
);
	import far_pkg::*;

	wide_t         rem_q;
	wide_t         quo_q;
	wide_t         dvs_q;
	cnt_t          cnt_q;
	logic          run_q;
	logic          done_q;
	logic [WIDE:0] trial;

	// shifted partial remainder minus divisor
	assign trial = {rem_q, quo_q[WIDE-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				dvs_q <= divisor;
				cnt_q <= '1;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (!trial[WIDE]) begin
					rem_q <= trial[WIDE-1:0];
					quo_q <= {quo_q[WIDE-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[WIDE-2:0], quo_q[WIDE-1]};
					quo_q <= {quo_q[WIDE-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

[rtl/far_dp.sv]
// datapath: operand registers, multipliers, sum, gcd and divider units, result register
`default_nettype none

module far_dp #(
	parameter int W = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [W-1:0]               first_numerator,
	input  wire logic [W-1:0]               first_denominator,
	input  wire logic [W-1:0]               second_numerator,
	input  wire logic [W-1:0]               second_denominator,
	input  wire far_pkg::far_cmd_t          cmd,
	output far_pkg::far_sts_t               sts,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic signed [far_pkg::NUM_W-1:0] sum_numerator,
	output logic [far_pkg::DEN_W-1:0]       sum_denominator,
	output logic                            status
);
	import far_pkg::*;

	logic signed [W-1:0] n1_q;
	logic signed [W-1:0] n2_q;
	logic [W-1:0]        d1_q;
	logic [W-1:0]        d2_q;
	logic [W-1:0]        m1_q;
	logic [W-1:0]        m2_q;
	wide_t               g_q;
	wide_t               g2_q;
	wide_t               lcm_q;
	wide_t               p1_q;
	wide_t               p2_q;
	wide_t               s_q;
	wide_t               qn_q;
	wide_t               qd_q;

	wide_t d1_ext;
	wide_t d2_ext;
	wide_t mag;
	wide_t neg_qn;

	logic signed [2*W:0]        prod1;
	logic signed [2*W:0]        prod2;
	logic [2*W-1:0]             prod_l;
	logic [2*W+WIDE:0]          ext1;
	logic [2*W+WIDE:0]          ext2;
	logic [2*W+WIDE-1:0]        ext_l;

	wide_t gcd_a;
	wide_t gcd_b;
	wide_t gcd_res;
	logic  gcd_done;
	wide_t div_n;
	wide_t div_d;
	wide_t div_q;
	logic  div_done;

	logic out_valid_q;

	// operand capture on an accepted request
	always_ff @(posedge clk) begin
		if (load) begin
			n1_q <= first_numerator;
			d1_q <= first_denominator;
			n2_q <= second_numerator;
			d2_q <= second_denominator;
		end
	end

	assign d1_ext = {{(WIDE-W){1'b0}}, d1_q};
	assign d2_ext = {{(WIDE-W){1'b0}}, d2_q};

	// magnitude of the wrapped sum
	assign mag    = s_q[WIDE-1] ? ('0 - s_q) : s_q;
	assign neg_qn = '0 - qn_q;

	// scale products and common denominator, wrapped to the internal width
	assign prod1  = n1_q * $signed({1'b0, m1_q});
	assign prod2  = n2_q * $signed({1'b0, m2_q});
	assign prod_l = m2_q * d2_q;
	assign ext1   = {{WIDE{prod1[2*W]}}, prod1};
	assign ext2   = {{WIDE{prod2[2*W]}}, prod2};
	assign ext_l  = {{WIDE{1'b0}}, prod_l};

	// gcd operand select
	assign gcd_a = (cmd.gcd_sel == GCD_DEN) ? d1_ext : mag;
	assign gcd_b = (cmd.gcd_sel == GCD_DEN) ? d2_ext : lcm_q;

	far_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.gcd_start),
		.a_in   (gcd_a),
		.b_in   (gcd_b),
		.result (gcd_res),
		.done   (gcd_done)
	);

	// divider operand select
	always_comb begin
		case (cmd.div_op)
			DIV_M1: begin
				div_n = d2_ext;
				div_d = g_q;
			end
			DIV_M2: begin
				div_n = d1_ext;
				div_d = g_q;
			end
			DIV_NUM: begin
				div_n = mag;
				div_d = g2_q;
			end
			DIV_DEN: begin
				div_n = lcm_q;
				div_d = g2_q;
			end
			default: begin
				div_n = lcm_q;
				div_d = g2_q;
			end
		endcase
	end

	far_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quotient (div_q),
		.done     (div_done)
	);

	// intermediate registers
	always_ff @(posedge clk) begin
		if (gcd_done) begin
			if (cmd.gcd_sel == GCD_DEN) begin
				g_q <= gcd_res;
			end else begin
				g2_q <= gcd_res;
			end
		end
		if (div_done) begin
			case (cmd.div_op)
				DIV_M1:  m1_q <= div_q[W-1:0];
				DIV_M2:  m2_q <= div_q[W-1:0];
				DIV_NUM: qn_q <= div_q;
				DIV_DEN: qd_q <= div_q;
				default: qd_q <= div_q;
			endcase
		end
		if (cmd.mul_en) begin
			p1_q  <= ext1[WIDE-1:0];
			p2_q  <= ext2[WIDE-1:0];
			lcm_q <= ext_l[WIDE-1:0];
		end
		if (cmd.sum_en) begin
			s_q <= p1_q + p2_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_kind)
				RES_ERR: begin
					sum_numerator   <= '0;
					sum_denominator <= '0;
					status          <= 1'b1;
				end
				RES_ZERO: begin
					sum_numerator   <= '0;
					sum_denominator <= DEN_W'(1);
					status          <= 1'b0;
				end
				default: begin
					sum_numerator   <= s_q[WIDE-1] ? neg_qn[NUM_W-1:0] : qn_q[NUM_W-1:0];
					sum_denominator <= qd_q[DEN_W-1:0];
					status          <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.den_zero = (d1_q == '0) || (d2_q == '0);
	assign sts.gcd_done = gcd_done;
	assign sts.div_done = div_done;
	assign sts.sum_zero = (s_q == '0);
	assign sts.out_full = out_valid_q && !out_ready;

endmodule

`default_nettype wire

[rtl/far_ctrl.sv]
// controller: sequences gcd, divisions, products and result write for one request
`default_nettype none

module far_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire far_pkg::far_sts_t sts,
	output far_pkg::far_cmd_t      cmd
);
	import far_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_GCD1,
		S_DIV1,
		S_DIV2,
		S_MUL,
		S_SUM,
		S_TEST,
		S_GCD2,
		S_DIV3,
		S_DIV4,
		S_FIN
	} state_t;

	state_t   state_q;
	far_cmd_t cmd_q;
	logic     in_ready_q;

	// state and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
			cmd_q      <= '0;
		end else begin
			cmd_q.gcd_start <= 1'b0;
			cmd_q.div_start <= 1'b0;
			cmd_q.mul_en    <= 1'b0;
			cmd_q.sum_en    <= 1'b0;
			cmd_q.res_load  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.den_zero) begin
						cmd_q.res_kind <= RES_ERR;
						state_q        <= S_FIN;
					end else begin
						cmd_q.gcd_start <= 1'b1;
						cmd_q.gcd_sel   <= GCD_DEN;
						state_q         <= S_GCD1;
					end
				end
				S_GCD1: begin
					if (sts.gcd_done) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_op    <= DIV_M1;
						state_q         <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (sts.div_done) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_op    <= DIV_M2;
						state_q         <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (sts.div_done) begin
						cmd_q.mul_en <= 1'b1;
						state_q      <= S_MUL;
					end
				end
				S_MUL: begin
					cmd_q.sum_en <= 1'b1;
					state_q      <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (sts.sum_zero) begin
						cmd_q.res_kind <= RES_ZERO;
						state_q        <= S_FIN;
					end else begin
						cmd_q.gcd_start <= 1'b1;
						cmd_q.gcd_sel   <= GCD_SUM;
						state_q         <= S_GCD2;
					end
				end
				S_GCD2: begin
					if (sts.gcd_done) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_op    <= DIV_NUM;
						state_q         <= S_DIV3;
					end
				end
				S_DIV3: begin
					if (sts.div_done) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_op    <= DIV_DEN;
						state_q         <= S_DIV4;
					end
				end
				S_DIV4: begin
					if (sts.div_done) begin
						cmd_q.res_kind <= RES_SUM;
						state_q        <= S_FIN;
					end
				end
				S_FIN: begin
					if (!sts.out_full) begin
						cmd_q.res_load <= 1'b1;
						in_ready_q     <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign cmd      = cmd_q;
	assign in_ready = in_ready_q;

endmodule

`default_nettype wire
